// File: rtl/core/glyph_to_planar_scanline_render_assert.svh
// assertion macros for the glyph to planar scanline renderer
// used by the top level rtl module in this folder; needs nothing else
`ifndef GLYPH_TO_PLANAR_SCANLINE_RENDER_ASSERT_SVH
`define GLYPH_TO_PLANAR_SCANLINE_RENDER_ASSERT_SVH

// same-cycle implication
`define GTPSR_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("glyph render check failed");

// next-cycle implication
`define GTPSR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("glyph render check failed");

`endif

// File: rtl/core/gtpsr_pkg.sv
// shared types, constants and the plane expansion function of the renderer
// depends on nothing
package gtpsr_pkg;

   localparam int GLYPH_COUNT = 256;
   localparam int GLYPH_ROWS = 9;
   localparam int GLYPH_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
   localparam int GLYPH_AW = $clog2(GLYPH_DEPTH);

   localparam logic [3:0] GLYPH_ROW_LIMIT = 4'(GLYPH_ROWS);
   localparam logic [4:0] LAST_LINE = 5'd17;
   localparam logic [15:0] ROW_BYTES = 16'd1440;
   localparam logic [15:0] LINE_BYTES = 16'd80;

   typedef logic [GLYPH_AW-1:0] glyph_addr_type;
   typedef logic [5:0] glyph_row_type;

   typedef enum logic {
      MODE_RENDER = 1'b0,
      MODE_LOAD   = 1'b1
   } mode_type;

   // bit "plane" of each pixel color, pixels doubled, leftmost in bit 11
   function automatic logic [11:0] plane_bits(glyph_row_type row, logic [3:0] fg,
                                              logic [3:0] bg, int plane);
      logic [11:0] bits;
      logic        b;
      bits = '0;
      for (int px = 0; px < 6; px++) begin
         b = row[5-px] ? fg[plane] : bg[plane];
         bits[11-2*px] = b;
         bits[10-2*px] = b;
      end
      return bits;
   endfunction

endpackage

// File: rtl/core/glyph_to_planar_scanline_render.sv
// top level of the glyph to planar scanline renderer
// depends on gtpsr_pkg, gtpsr_glyph_mem and the assertion header

// A load item (tuser 1) writes one glyph row and gives no result; a row index
// above 8 is dropped. A render item (tuser 0) gives 18 scanline items, one per
// cycle while rsp_tready does not stall the output, as the single read port of
// the glyph store is read once per scanline; so render items are taken back to
// back, the next one in the cycle that issues the last read of the current one.
// The first result passes the cell, read stage and output registers. Loads are
// taken while a cell renders if they target another character code, or in that
// final read cycle. Glyph rows must be loaded before they are rendered.
module glyph_to_planar_scanline_render (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // char_code[7:0], attribute[15:8], column[21:16], text_row[26:22],
   // glyph_line[30:27], glyph_bits[36:31], zero[39:37]
   input  logic [39:0] req_tdata,
   // mode
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // byte_address[15:0], plane0_bits[27:16], plane1_bits[39:28],
   // plane2_bits[51:40], plane3_bits[63:52]
   output logic [63:0] rsp_tdata,
   // odd_column
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   logic [7:0] in_code;
   logic [7:0] in_attr;
   logic [5:0] in_column;
   logic [4:0] in_trow;
   logic [3:0] in_gline;
   logic [5:0] in_gbits;
   gtpsr_pkg::mode_type in_mode;

   assign in_code   = req_tdata[7:0];
   assign in_attr   = req_tdata[15:8];
   assign in_column = req_tdata[21:16];
   assign in_trow   = req_tdata[26:22];
   assign in_gline  = req_tdata[30:27];
   assign in_gbits  = req_tdata[36:31];
   assign in_mode   = gtpsr_pkg::mode_type'(req_tuser);

   logic        busy_ff, busy_in;
   logic [4:0]  line_ff, line_in;
   logic [7:0]  code_ff, code_in;
   logic [7:0]  attr_ff, attr_in;
   logic        odd_ff, odd_in;
   logic [15:0] addr_ff, addr_in;

   logic        b_valid_ff, b_valid_in;
   logic [7:0]  b_attr_ff, b_attr_in;
   logic        b_odd_ff, b_odd_in;
   logic [15:0] b_addr_ff, b_addr_in;
   logic        b_last_ff, b_last_in;

   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_data_ff, out_data_in;
   logic        out_odd_ff, out_odd_in;
   logic        out_last_ff, out_last_in;

   logic        req_accept;
   logic        render_go;
   logic        load_go;
   logic        advance_out;
   logic        issue;
   logic        last_issue;
   logic [7:0]  col3;
   logic [15:0] base_addr;

   gtpsr_pkg::glyph_addr_type wr_addr;
   gtpsr_pkg::glyph_addr_type rd_addr;
   gtpsr_pkg::glyph_row_type  rd_row;

   assign advance_out = b_valid_ff && (!out_valid_ff || rsp_tready);
   assign issue       = busy_ff && (!b_valid_ff || advance_out);
   assign last_issue  = issue && (line_ff == gtpsr_pkg::LAST_LINE);

   assign req_tready = !busy_ff || last_issue ||
                       ((in_mode == gtpsr_pkg::MODE_LOAD) && (in_code != code_ff));
   assign req_accept = req_tvalid && req_tready;
   assign render_go  = req_accept && (in_mode == gtpsr_pkg::MODE_RENDER);
   assign load_go    = req_accept && (in_mode == gtpsr_pkg::MODE_LOAD) &&
                       (in_gline < gtpsr_pkg::GLYPH_ROW_LIMIT);

   // code*9 + row
   assign wr_addr = gtpsr_pkg::GLYPH_AW'({in_code, 3'b000}) +
                    gtpsr_pkg::GLYPH_AW'(in_code) + gtpsr_pkg::GLYPH_AW'(in_gline);
   assign rd_addr = gtpsr_pkg::GLYPH_AW'({code_ff, 3'b000}) +
                    gtpsr_pkg::GLYPH_AW'(code_ff) + gtpsr_pkg::GLYPH_AW'(line_ff[4:1]);

   assign col3      = {2'b00, in_column} + {1'b0, in_column, 1'b0};
   assign base_addr = 16'(16'(in_trow) * gtpsr_pkg::ROW_BYTES) + 16'(col3[7:1]);

   gtpsr_glyph_mem u_glyph_mem (
      .clock   (clock),
      .wr_en   (load_go),
      .wr_addr (wr_addr),
      .wr_data (in_gbits),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_row)
   );

   always_comb begin
      busy_in = busy_ff;
      line_in = line_ff;
      code_in = code_ff;
      attr_in = attr_ff;
      odd_in  = odd_ff;
      addr_in = addr_ff;
      if (render_go) begin
         busy_in = 1'b1;
         line_in = '0;
         code_in = in_code;
         attr_in = in_attr;
         odd_in  = in_column[0];
         addr_in = base_addr;
      end else if (issue) begin
         busy_in = !last_issue;
         line_in = line_ff + 5'd1;
         addr_in = addr_ff + gtpsr_pkg::LINE_BYTES;
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      b_attr_in  = b_attr_ff;
      b_odd_in   = b_odd_ff;
      b_addr_in  = b_addr_ff;
      b_last_in  = b_last_ff;
      if (issue) begin
         b_valid_in = 1'b1;
         b_attr_in  = attr_ff;
         b_odd_in   = odd_ff;
         b_addr_in  = addr_ff;
         b_last_in  = (line_ff == gtpsr_pkg::LAST_LINE);
      end else if (advance_out) begin
         b_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_odd_in   = out_odd_ff;
      out_last_in  = out_last_ff;
      if (advance_out) begin
         out_valid_in = 1'b1;
         out_data_in  = {gtpsr_pkg::plane_bits(rd_row, b_attr_ff[3:0], b_attr_ff[7:4], 3),
                         gtpsr_pkg::plane_bits(rd_row, b_attr_ff[3:0], b_attr_ff[7:4], 2),
                         gtpsr_pkg::plane_bits(rd_row, b_attr_ff[3:0], b_attr_ff[7:4], 1),
                         gtpsr_pkg::plane_bits(rd_row, b_attr_ff[3:0], b_attr_ff[7:4], 0),
                         b_addr_ff};
         out_odd_in   = b_odd_ff;
         out_last_in  = b_last_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         line_ff      <= '0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         line_ff      <= line_in;
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      attr_ff     <= attr_in;
      odd_ff      <= odd_in;
      addr_ff     <= addr_in;
      b_attr_ff   <= b_attr_in;
      b_odd_ff    <= b_odd_in;
      b_addr_ff   <= b_addr_in;
      b_last_ff   <= b_last_in;
      out_data_ff <= out_data_in;
      out_odd_ff  <= out_odd_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_odd_ff;
   assign rsp_tlast  = out_last_ff;

`include "glyph_to_planar_scanline_render_assert.svh"

   `GTPSR_ASSERT_NOW(a_line_in_range, clock, reset, busy_ff, line_ff <= gtpsr_pkg::LAST_LINE)
   `GTPSR_ASSERT_NEXT(a_render_starts, clock, reset, render_go, busy_ff && (line_ff == '0))
   `GTPSR_ASSERT_NOW(a_no_load_hazard, clock, reset, load_go && busy_ff && !last_issue, in_code != code_ff)
   `GTPSR_ASSERT_NEXT(a_issue_fills_stage, clock, reset, issue, b_valid_ff)
   `GTPSR_ASSERT_NEXT(a_last_reaches_out, clock, reset, advance_out && b_last_ff, rsp_tvalid && rsp_tlast)

endmodule

// File: rtl/core/gtpsr_glyph_mem.sv
// glyph store: one write port, one registered read port
// depends on gtpsr_pkg
module gtpsr_glyph_mem (
   input  logic                     clock,
   input  logic                     wr_en,
   input  gtpsr_pkg::glyph_addr_type wr_addr,
   input  gtpsr_pkg::glyph_row_type  wr_data,
   input  logic                     rd_en,
   input  gtpsr_pkg::glyph_addr_type rd_addr,
   output gtpsr_pkg::glyph_row_type  rd_data
);

   gtpsr_pkg::glyph_row_type mem [0:gtpsr_pkg::GLYPH_DEPTH-1];
   gtpsr_pkg::glyph_row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
